@@ rtl/cic_pkg.sv @@
package cic_pkg;

    // Coordinate word width; every internal width in the datapath follows from it.
    localparam int CW = 32;

    // Configuration register widths, reset values and indexes.
    localparam int CTOL_W = 16;
    localparam int ATOL_W = 32;
    localparam logic [CTOL_W-1:0] CTOL_RESET = 16'd1;
    localparam logic [ATOL_W-1:0] ATOL_RESET = 32'd42950;
    localparam logic REG_COORD_TOL = 1'b0;
    localparam logic REG_AREA_TOL = 1'b1;

    typedef enum logic [1:0] {
        ST_OK,
        ST_FLAT,
        ST_PARALLEL,
        ST_OVERFLOW
    } status_t;

    // Which pair of bisectors sets the centre.
    typedef enum logic [1:0] {
        CASE_GEN,
        CASE_AB,
        CASE_BC,
        CASE_FLAT
    } case_t;

    typedef struct packed {
        logic signed [CW-1:0] query_x;
        logic signed [CW-1:0] query_y;
        logic signed [CW-1:0] vert_a_x;
        logic signed [CW-1:0] vert_a_y;
        logic signed [CW-1:0] vert_b_x;
        logic signed [CW-1:0] vert_b_y;
        logic signed [CW-1:0] vert_c_x;
        logic signed [CW-1:0] vert_c_y;
    } req_t;

    typedef struct packed {
        logic signed [CW-1:0] center_x;
        logic signed [CW-1:0] center_y;
        logic [CW-1:0]        radius;
        logic                 inside_res;
        status_t              status;
    } res_t;

    // Points carried alongside the centre computation.
    typedef struct packed {
        logic signed [CW-1:0] xb;
        logic signed [CW-1:0] yb;
        logic signed [CW-1:0] qx;
        logic signed [CW-1:0] qy;
    } pt_t;

    // Side information that travels with the divider cells.
    typedef struct packed {
        logic    sg_x;
        logic    sg_y;
        logic    big_x;
        logic    big_y;
        status_t st;
        pt_t     pt;
    } mid_t;

    // Side information that travels with the square root cells.
    typedef struct packed {
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        logic                 ovf;
        logic                 in_circ;
        status_t              st;
    } fin_t;

    // Saturate a rounded quotient magnitude to a signed coordinate.
    // Returns the overflow flag on top of the coordinate.
    function automatic logic [CW:0] sat_coord(logic [CW-1:0] q, logic big, logic neg);
        logic ovf;
        logic [CW-1:0] val;
        if (!neg)
        begin
            ovf = big | q[CW-1];
            val = ovf ? {1'b0, {(CW-1){1'b1}}} : q;
        end
        else
        begin
            ovf = big | (q[CW-1] & (|q[CW-2:0]));
            val = ovf ? {1'b1, {(CW-1){1'b0}}} : (~q + 1'b1);
        end
        return {ovf, val};
    endfunction

endpackage

@@ rtl/cic_div_cell.sv @@
module cic_div_cell #(
    parameter int QW = 32,
    parameter int RW = 101,
    parameter int DW = 69,
    parameter int B = 0
) (
    input  logic          clk,
    input  logic          en,
    input  logic [RW-1:0] rem_in,
    input  logic [DW-1:0] den_in,
    input  logic [QW-1:0] quo_in,
    output logic [RW-1:0] rem_reg,
    output logic [DW-1:0] den_reg,
    output logic [QW-1:0] quo_reg
);

    logic [RW-1:0] trial;
    logic          ge;
    logic [RW-1:0] rem_next;
    logic [QW-1:0] quo_next;

    // One restoring step: try the divisor at this cell's bit weight.
    always_comb
    begin
        trial = RW'(den_in) << B;
        ge = rem_in >= trial;
        rem_next = ge ? (rem_in - trial) : rem_in;
        quo_next = quo_in;
        quo_next[B] = ge;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            den_reg <= den_in;
            quo_reg <= quo_next;
        end
    end

endmodule

@@ rtl/cic_sqrt_cell.sv @@
module cic_sqrt_cell #(
    parameter int RB = 34,
    parameter int SW = 69,
    parameter int B = 0
) (
    input  logic          clk,
    input  logic          en,
    input  logic [SW-1:0] rem_in,
    input  logic [RB-1:0] root_in,
    output logic [SW-1:0] rem_reg,
    output logic [RB-1:0] root_reg
);

    logic [SW-1:0] trial;
    logic          ge;
    logic [SW-1:0] rem_next;
    logic [RB-1:0] root_next;

    // Decide one root bit: (r + 2^B)^2 - r^2 = r*2^(B+1) + 2^(2B).
    always_comb
    begin
        trial = (SW'(root_in) << (B + 1)) | (SW'(1) << (2 * B));
        ge = rem_in >= trial;
        rem_next = ge ? (rem_in - trial) : rem_in;
        root_next = root_in;
        root_next[B] = ge;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            root_reg <= root_next;
        end
    end

endmodule

@@ rtl/circumcircle_incircle_test.sv @@
// Circumcircle in-circle test.
// The req channel carries one word: a query point and three triangle vertices,
// signed Q16.16. The res channel returns one word per request: the circumcentre,
// the radius, an inside flag and a status code. Both channels use valid/stall;
// a word moves on a clock edge where valid is high and stall is low.
// The datapath is a fully pipelined chain: eight front stages (differences,
// products, split partial products of the wide numerator terms, bisector
// numerators), one divider cell per quotient bit for each centre coordinate,
// four stages for the distances, and one square root cell per radius bit.
// One request is accepted every cycle while req_stall is low.
// When res is stalled, one further word is caught in a skid register; only then
// does req_stall rise and the whole chain hold. req_stall is a register output.
// Reset empties the pipeline and sets coord_tolerance to 1 and area_tolerance
// to 42950. Registers sit on an APB port at byte addresses 0 and 4 and should
// be written only while no request is in flight.
module circumcircle_incircle_test (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  cic_pkg::req_t       req,
    output logic                res_valid,
    input  logic                res_stall,
    output cic_pkg::res_t       res,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    import cic_pkg::*;

    localparam int W = CW;
    localparam int DFW = W + 1;
    localparam int PRW = 2 * W + 2;
    localparam int DSW = 2 * W + 4;
    localparam int NSW = 3 * W + 8;
    localparam int NW = NSW + 1;
    localparam int DW = DSW + 1;
    localparam int RW = DW + W;
    localparam int RB = W + 2;
    localparam int SW = 2 * RB + 1;
    localparam int LW = DSW / 2;
    localparam int PPW = DFW + LW + 1;
    localparam int NST = 8 + W + 4 + RB;

    // Configuration registers.
    logic [CTOL_W-1:0] ctol_reg;
    logic [ATOL_W-1:0] atol_reg;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctol_reg <= CTOL_RESET;
            atol_reg <= ATOL_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[2])
                REG_COORD_TOL: ctol_reg <= pwdata[CTOL_W-1:0];
                REG_AREA_TOL:  atol_reg <= pwdata[ATOL_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_COORD_TOL: prdata = 32'(ctol_reg);
            REG_AREA_TOL:  prdata = 32'(atol_reg);
            default:       prdata = '0;
        endcase
    end

    // Pipeline control: the chain moves unless the skid register is full.
    logic           adv;
    logic [NST-1:0] pv_reg;
    logic           skid_vld_reg;
    logic           out_vld_reg;
    res_t           skid_reg;
    res_t           out_reg;

    assign adv = !skid_vld_reg;
    assign req_stall = skid_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg <= '0;
        end
        else if (adv)
        begin
            pv_reg <= {pv_reg[NST-2:0], req_valid};
        end
    end

    // Stage 1: input register.
    req_t req_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            req_reg <= req;
        end
    end

    // Stage 2: edge differences and the horizontal-edge decision.
    logic signed [DFW-1:0] ay_c;
    logic signed [DFW-1:0] ey_c;
    logic [DFW-1:0]        ay_mag;
    logic [DFW-1:0]        ey_mag;
    logic                  flat_ab;
    logic                  flat_bc;
    case_t                 cs_c;

    always_comb
    begin
        ay_c = DFW'(req_reg.vert_a_y) - DFW'(req_reg.vert_b_y);
        ey_c = DFW'(req_reg.vert_c_y) - DFW'(req_reg.vert_b_y);
        ay_mag = ay_c[DFW-1] ? DFW'(-ay_c) : DFW'(ay_c);
        ey_mag = ey_c[DFW-1] ? DFW'(-ey_c) : DFW'(ey_c);
        flat_ab = ay_mag < DFW'(ctol_reg);
        flat_bc = ey_mag < DFW'(ctol_reg);
        if (flat_ab && flat_bc)
        begin
            cs_c = CASE_FLAT;
        end
        else if (flat_ab)
        begin
            cs_c = CASE_AB;
        end
        else if (flat_bc)
        begin
            cs_c = CASE_BC;
        end
        else
        begin
            cs_c = CASE_GEN;
        end
    end

    logic signed [DFW-1:0] ax2_reg, ay2_reg, ex2_reg, ey2_reg;
    logic signed [DFW-1:0] axc2_reg, sab2_reg, sbc2_reg, hxn2_reg;
    case_t                 cs2_reg;
    pt_t                   pt2_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ax2_reg <= DFW'(req_reg.vert_a_x) - DFW'(req_reg.vert_b_x);
            ay2_reg <= ay_c;
            ex2_reg <= DFW'(req_reg.vert_c_x) - DFW'(req_reg.vert_b_x);
            ey2_reg <= ey_c;
            axc2_reg <= DFW'(req_reg.vert_a_x) - DFW'(req_reg.vert_c_x);
            sab2_reg <= DFW'(req_reg.vert_a_y) + DFW'(req_reg.vert_b_y);
            sbc2_reg <= DFW'(req_reg.vert_b_y) + DFW'(req_reg.vert_c_y);
            hxn2_reg <= (cs_c == CASE_AB) ?
                        DFW'(req_reg.vert_a_x) + DFW'(req_reg.vert_b_x) :
                        DFW'(req_reg.vert_b_x) + DFW'(req_reg.vert_c_x);
            cs2_reg <= cs_c;
            pt2_reg <= '{xb: req_reg.vert_b_x, yb: req_reg.vert_b_y,
                         qx: req_reg.query_x, qy: req_reg.query_y};
        end
    end

    // Stage 3: squares, cross products and the horizontal-case products.
    logic signed [DFW-1:0] m1a, m1b, m2a;

    always_comb
    begin
        if (cs2_reg == CASE_AB)
        begin
            m1a = sbc2_reg;
            m1b = ey2_reg;
            m2a = ex2_reg;
        end
        else
        begin
            m1a = sab2_reg;
            m1b = ay2_reg;
            m2a = ax2_reg;
        end
    end

    logic signed [PRW-1:0] pax3_reg, pay3_reg, pex3_reg, pey3_reg;
    logic signed [PRW-1:0] c13_reg, c23_reg, h13_reg, h23_reg;
    logic signed [DFW-1:0] ax3_reg, ay3_reg, ex3_reg, ey3_reg, hxn3_reg;
    case_t                 cs3_reg;
    pt_t                   pt3_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pax3_reg <= PRW'(ax2_reg) * PRW'(ax2_reg);
            pay3_reg <= PRW'(ay2_reg) * PRW'(ay2_reg);
            pex3_reg <= PRW'(ex2_reg) * PRW'(ex2_reg);
            pey3_reg <= PRW'(ey2_reg) * PRW'(ey2_reg);
            c13_reg <= PRW'(ax2_reg) * PRW'(ey2_reg);
            c23_reg <= PRW'(ay2_reg) * PRW'(ex2_reg);
            h13_reg <= PRW'(m1a) * PRW'(m1b);
            h23_reg <= PRW'(m2a) * PRW'(axc2_reg);
            ax3_reg <= ax2_reg;
            ay3_reg <= ay2_reg;
            ex3_reg <= ex2_reg;
            ey3_reg <= ey2_reg;
            hxn3_reg <= hxn2_reg;
            cs3_reg <= cs2_reg;
            pt3_reg <= pt2_reg;
        end
    end

    // Stage 4: squared edge lengths, twice the cross product, horizontal terms.
    logic signed [DSW-1:0] la4_reg, lc4_reg, dd4_reg, hy4_reg, hyd4_reg;
    logic signed [DFW-1:0] ax4_reg, ay4_reg, ex4_reg, ey4_reg, hxn4_reg;
    case_t                 cs4_reg;
    pt_t                   pt4_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            la4_reg <= DSW'(pax3_reg) + DSW'(pay3_reg);
            lc4_reg <= DSW'(pex3_reg) + DSW'(pey3_reg);
            dd4_reg <= (DSW'(c13_reg) - DSW'(c23_reg)) <<< 1;
            if (cs3_reg == CASE_AB)
            begin
                hy4_reg <= DSW'(h13_reg) - DSW'(h23_reg);
                hyd4_reg <= DSW'(ey3_reg) <<< 1;
            end
            else
            begin
                hy4_reg <= -(DSW'(h13_reg) + DSW'(h23_reg));
                hyd4_reg <= -(DSW'(ay3_reg) <<< 1);
            end
            ax4_reg <= ax3_reg;
            ay4_reg <= ay3_reg;
            ex4_reg <= ex3_reg;
            ey4_reg <= ey3_reg;
            hxn4_reg <= hxn3_reg;
            cs4_reg <= cs3_reg;
            pt4_reg <= pt3_reg;
        end
    end

    // Stage 5a: split the wide operands in halves and form the partial products.
    // The low half is taken as unsigned, the high half keeps the sign.
    logic signed [LW:0]       ddl_c, lal_c, lcl_c;
    logic signed [DSW-LW-1:0] ddh_c, lah_c, lch_c;

    assign ddl_c = {1'b0, dd4_reg[LW-1:0]};
    assign lal_c = {1'b0, la4_reg[LW-1:0]};
    assign lcl_c = {1'b0, lc4_reg[LW-1:0]};
    assign ddh_c = dd4_reg[DSW-1:LW];
    assign lah_c = la4_reg[DSW-1:LW];
    assign lch_c = lc4_reg[DSW-1:LW];

    logic signed [PPW-1:0] p1l_reg, p2l_reg, p3l_reg, p4l_reg, p5l_reg, p6l_reg;
    logic signed [PPW-1:0] p1h_reg, p2h_reg, p3h_reg, p4h_reg, p5h_reg, p6h_reg;
    logic signed [DSW-1:0] ddp_reg, hyp_reg, hydp_reg;
    logic signed [DFW-1:0] hxnp_reg;
    logic                  dzp_reg;
    case_t                 csp_reg;
    pt_t                   ptp_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1l_reg <= PPW'(pt4_reg.xb) * PPW'(ddl_c);
            p1h_reg <= PPW'(pt4_reg.xb) * PPW'(ddh_c);
            p2l_reg <= PPW'(ey4_reg) * PPW'(lal_c);
            p2h_reg <= PPW'(ey4_reg) * PPW'(lah_c);
            p3l_reg <= PPW'(ay4_reg) * PPW'(lcl_c);
            p3h_reg <= PPW'(ay4_reg) * PPW'(lch_c);
            p4l_reg <= PPW'(pt4_reg.yb) * PPW'(ddl_c);
            p4h_reg <= PPW'(pt4_reg.yb) * PPW'(ddh_c);
            p5l_reg <= PPW'(ax4_reg) * PPW'(lcl_c);
            p5h_reg <= PPW'(ax4_reg) * PPW'(lch_c);
            p6l_reg <= PPW'(ex4_reg) * PPW'(lal_c);
            p6h_reg <= PPW'(ex4_reg) * PPW'(lah_c);
            ddp_reg <= dd4_reg;
            hyp_reg <= hy4_reg;
            hydp_reg <= hyd4_reg;
            hxnp_reg <= hxn4_reg;
            dzp_reg <= dd4_reg == '0;
            csp_reg <= cs4_reg;
            ptp_reg <= pt4_reg;
        end
    end

    // Stage 5b: join the partial products into the general-case numerator terms.
    logic signed [NSW-1:0] t15_reg, t25_reg, t35_reg, t45_reg, t55_reg, t65_reg;
    logic signed [DSW-1:0] dd5_reg, hy5_reg, hyd5_reg;
    logic signed [DFW-1:0] hxn5_reg;
    logic                  dz5_reg;
    case_t                 cs5_reg;
    pt_t                   pt5_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t15_reg <= (NSW'(p1h_reg) <<< LW) + NSW'(p1l_reg);
            t25_reg <= (NSW'(p2h_reg) <<< LW) + NSW'(p2l_reg);
            t35_reg <= (NSW'(p3h_reg) <<< LW) + NSW'(p3l_reg);
            t45_reg <= (NSW'(p4h_reg) <<< LW) + NSW'(p4l_reg);
            t55_reg <= (NSW'(p5h_reg) <<< LW) + NSW'(p5l_reg);
            t65_reg <= (NSW'(p6h_reg) <<< LW) + NSW'(p6l_reg);
            dd5_reg <= ddp_reg;
            hy5_reg <= hyp_reg;
            hyd5_reg <= hydp_reg;
            hxn5_reg <= hxnp_reg;
            dz5_reg <= dzp_reg;
            cs5_reg <= csp_reg;
            pt5_reg <= ptp_reg;
        end
    end

    // Stage 6: pick numerator and denominator, form the rounding operands.
    logic signed [NSW-1:0] n_x, n_y;
    logic signed [DSW-1:0] d_x, d_y;
    logic [NSW-1:0]        na_x, na_y;
    logic [DSW-1:0]        da_x, da_y;
    status_t               st_c;

    always_comb
    begin
        if (cs5_reg == CASE_GEN)
        begin
            n_x = t15_reg + t25_reg - t35_reg;
            n_y = t45_reg + t55_reg - t65_reg;
            d_x = dd5_reg;
            d_y = dd5_reg;
        end
        else
        begin
            n_x = NSW'(hxn5_reg);
            n_y = NSW'(hy5_reg);
            d_x = DSW'(2);
            d_y = hyd5_reg;
        end
        na_x = n_x[NSW-1] ? NSW'(-n_x) : NSW'(n_x);
        na_y = n_y[NSW-1] ? NSW'(-n_y) : NSW'(n_y);
        da_x = d_x[DSW-1] ? DSW'(-d_x) : DSW'(d_x);
        da_y = d_y[DSW-1] ? DSW'(-d_y) : DSW'(d_y);
        if (cs5_reg == CASE_FLAT)
        begin
            st_c = ST_FLAT;
        end
        else if (cs5_reg == CASE_GEN && dz5_reg)
        begin
            st_c = ST_PARALLEL;
        end
        else
        begin
            st_c = ST_OK;
        end
    end

    logic [NW-1:0] nm6x_reg, nm6y_reg;
    logic [DW-1:0] dm6x_reg, dm6y_reg;
    mid_t          mid6_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            nm6x_reg <= (NW'(na_x) << 1) + NW'(da_x);
            nm6y_reg <= (NW'(na_y) << 1) + NW'(da_y);
            dm6x_reg <= DW'(da_x) << 1;
            dm6y_reg <= DW'(da_y) << 1;
            mid6_reg <= '{sg_x: n_x[NSW-1] ^ d_x[DSW-1], sg_y: n_y[NSW-1] ^ d_y[DSW-1],
                          big_x: 1'b0, big_y: 1'b0, st: st_c, pt: pt5_reg};
        end
    end

    // Stage 7: detect quotients too large for the divider cells.
    logic [RW-1:0] drx [0:W];
    logic [RW-1:0] dry [0:W];
    logic [DW-1:0] ddx [0:W];
    logic [DW-1:0] ddy [0:W];
    logic [W-1:0]  dqx [0:W];
    logic [W-1:0]  dqy [0:W];
    mid_t          mid7_reg;
    logic [RW-1:0] rem7x_reg, rem7y_reg;
    logic [DW-1:0] dm7x_reg, dm7y_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem7x_reg <= nm6x_reg[RW-1:0];
            rem7y_reg <= nm6y_reg[RW-1:0];
            dm7x_reg <= dm6x_reg;
            dm7y_reg <= dm6y_reg;
            mid7_reg <= '{sg_x: mid6_reg.sg_x, sg_y: mid6_reg.sg_y,
                          big_x: nm6x_reg >= (NW'(dm6x_reg) << W),
                          big_y: nm6y_reg >= (NW'(dm6y_reg) << W),
                          st: mid6_reg.st, pt: mid6_reg.pt};
        end
    end

    assign drx[0] = rem7x_reg;
    assign dry[0] = rem7y_reg;
    assign ddx[0] = dm7x_reg;
    assign ddy[0] = dm7y_reg;
    assign dqx[0] = '0;
    assign dqy[0] = '0;

    // Divider chain: one cell per quotient bit, most significant first.
    for (genvar k = 0; k < W; k++)
    begin : g_div
        cic_div_cell #(.QW(W), .RW(RW), .DW(DW), .B(W - 1 - k)) u_cell_x (
            .clk     (clk),
            .en      (adv),
            .rem_in  (drx[k]),
            .den_in  (ddx[k]),
            .quo_in  (dqx[k]),
            .rem_reg (drx[k+1]),
            .den_reg (ddx[k+1]),
            .quo_reg (dqx[k+1])
        );
        cic_div_cell #(.QW(W), .RW(RW), .DW(DW), .B(W - 1 - k)) u_cell_y (
            .clk     (clk),
            .en      (adv),
            .rem_in  (dry[k]),
            .den_in  (ddy[k]),
            .quo_in  (dqy[k]),
            .rem_reg (dry[k+1]),
            .den_reg (ddy[k+1]),
            .quo_reg (dqy[k+1])
        );
    end

    mid_t dmid_reg [0:W-1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dmid_reg[0] <= mid7_reg;
            for (int k = 1; k < W; k++)
            begin
                dmid_reg[k] <= dmid_reg[k-1];
            end
        end
    end

    // Stage 8: signed, saturated centre.
    logic [W:0] satx, saty;
    mid_t       dend;

    assign dend = dmid_reg[W-1];
    assign satx = sat_coord(dqx[W], dend.big_x, dend.sg_x);
    assign saty = sat_coord(dqy[W], dend.big_y, dend.sg_y);

    logic signed [W-1:0] cx8_reg, cy8_reg;
    logic                ovf8_reg;
    status_t             st8_reg;
    pt_t                 pt8_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cx8_reg <= satx[W-1:0];
            cy8_reg <= saty[W-1:0];
            ovf8_reg <= satx[W] | saty[W];
            st8_reg <= dend.st;
            pt8_reg <= dend.pt;
        end
    end

    // Stage 9: offsets of B and of the query point from the centre.
    logic signed [DFW-1:0] dxr9_reg, dyr9_reg, dxq9_reg, dyq9_reg;
    logic signed [W-1:0]   cx9_reg, cy9_reg;
    logic                  ovf9_reg;
    status_t               st9_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dxr9_reg <= DFW'(pt8_reg.xb) - DFW'(cx8_reg);
            dyr9_reg <= DFW'(pt8_reg.yb) - DFW'(cy8_reg);
            dxq9_reg <= DFW'(pt8_reg.qx) - DFW'(cx8_reg);
            dyq9_reg <= DFW'(pt8_reg.qy) - DFW'(cy8_reg);
            cx9_reg <= cx8_reg;
            cy9_reg <= cy8_reg;
            ovf9_reg <= ovf8_reg;
            st9_reg <= st8_reg;
        end
    end

    // Stage 10: squared offsets.
    logic signed [PRW-1:0] sq1_reg, sq2_reg, sq3_reg, sq4_reg;
    logic signed [W-1:0]   cx10_reg, cy10_reg;
    logic                  ovf10_reg;
    status_t               st10_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq1_reg <= PRW'(dxr9_reg) * PRW'(dxr9_reg);
            sq2_reg <= PRW'(dyr9_reg) * PRW'(dyr9_reg);
            sq3_reg <= PRW'(dxq9_reg) * PRW'(dxq9_reg);
            sq4_reg <= PRW'(dyq9_reg) * PRW'(dyq9_reg);
            cx10_reg <= cx9_reg;
            cy10_reg <= cy9_reg;
            ovf10_reg <= ovf9_reg;
            st10_reg <= st9_reg;
        end
    end

    // Stage 11: squared radius, squared query distance and the inside decision.
    logic [DSW-1:0] rsq_c, dsq_c;

    assign rsq_c = DSW'(unsigned'(sq1_reg)) + DSW'(unsigned'(sq2_reg));
    assign dsq_c = DSW'(unsigned'(sq3_reg)) + DSW'(unsigned'(sq4_reg));

    logic [SW-1:0] srem [0:RB];
    logic [RB-1:0] sroot [0:RB];
    logic [SW-1:0] rsq11_reg;
    fin_t          fin11_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rsq11_reg <= SW'(rsq_c);
            fin11_reg <= '{cx: cx10_reg, cy: cy10_reg, ovf: ovf10_reg,
                           in_circ: dsq_c <= rsq_c + DSW'(atol_reg), st: st10_reg};
        end
    end

    assign srem[0] = rsq11_reg;
    assign sroot[0] = '0;

    // Square root chain: one cell per root bit, most significant first.
    for (genvar k = 0; k < RB; k++)
    begin : g_sqrt
        cic_sqrt_cell #(.RB(RB), .SW(SW), .B(RB - 1 - k)) u_cell (
            .clk      (clk),
            .en       (adv),
            .rem_in   (srem[k]),
            .root_in  (sroot[k]),
            .rem_reg  (srem[k+1]),
            .root_reg (sroot[k+1])
        );
    end

    fin_t sfin_reg [0:RB-1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sfin_reg[0] <= fin11_reg;
            for (int k = 1; k < RB; k++)
            begin
                sfin_reg[k] <= sfin_reg[k-1];
            end
        end
    end

    // Result word: radius saturation, status, and zeros for degenerate triangles.
    fin_t  fend;
    logic  rad_ovf;
    res_t  res_c;

    assign fend = sfin_reg[RB-1];
    assign rad_ovf = |sroot[RB][RB-1:W];

    always_comb
    begin
        if (fend.st != ST_OK)
        begin
            res_c = '{center_x: '0, center_y: '0, radius: '0, inside_res: 1'b0,
                      status: fend.st};
        end
        else
        begin
            res_c.center_x = fend.cx;
            res_c.center_y = fend.cy;
            res_c.radius = rad_ovf ? {W{1'b1}} : sroot[RB][W-1:0];
            res_c.inside_res = fend.in_circ;
            res_c.status = (fend.ovf || rad_ovf) ? ST_OVERFLOW : ST_OK;
        end
    end

    // Output register with one skid word behind it.
    logic end_vld;
    logic out_take;

    assign end_vld = pv_reg[NST-1];
    assign out_take = out_vld_reg && !res_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (skid_vld_reg)
        begin
            if (!out_vld_reg || out_take)
            begin
                out_vld_reg <= 1'b1;
                skid_vld_reg <= 1'b0;
            end
        end
        else if (end_vld)
        begin
            if (out_vld_reg && !out_take)
            begin
                skid_vld_reg <= 1'b1;
            end
            else
            begin
                out_vld_reg <= 1'b1;
            end
        end
        else if (out_take)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_vld_reg)
        begin
            if (!out_vld_reg || out_take)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (end_vld)
        begin
            if (out_vld_reg && !out_take)
            begin
                skid_reg <= res_c;
            end
            else
            begin
                out_reg <= res_c;
            end
        end
    end

    assign res_valid = out_vld_reg;
    assign res = out_reg;

    // A word in the skid register always has a word ahead of it.
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_vld_reg |-> out_vld_reg)
        else $error("skid word without output word");

    // Degenerate triangles report an all-zero result.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res.status == ST_FLAT || res.status == ST_PARALLEL) |->
        (res.center_x == '0 && res.center_y == '0 && res.radius == '0 && !res.inside_res))
        else $error("degenerate result not cleared");

    // The pipeline holds while the skid register is full.
    assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(pv_reg))
        else $error("pipeline moved while held");

endmodule

@@ verif/testbench.sv @@
module testbench;
    import cic_pkg::*;

    typedef logic signed [255:0] wide_t;

    localparam int PIPE_LATENCY = 2 * CW + 14;
    localparam int HALF_PERIOD = 6;

    logic          clk;
    logic          rst_n;
    logic          req_valid;
    logic          req_stall;
    req_t          req;
    logic          res_valid;
    logic          res_stall;
    res_t          res;
    logic          psel;
    logic          penable;
    logic          pwrite;
    logic [2:0]    paddr;
    logic [31:0]   pwdata;
    logic [31:0]   prdata;
    logic          pready;

    // Mirror of the tolerance registers, updated as each write lands.
    logic [CTOL_W-1:0] coord_tol_m;
    logic [ATOL_W-1:0] area_tol_m;

    req_t circle_pending[$];
    res_t circle_expected[$];

    // Idling controls for the driver and monitor; no_idle is shared by both.
    bit no_idle;
    int hold_requests;
    int hold_served;
    int hold_left;
    int send_gap;
    int recv_gap;

    int words_sent;
    int words_checked;
    int mismatches;
    int status_seen[4];

    circumcircle_incircle_test i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #(HALF_PERIOD) clk = ~clk;

    function automatic wide_t abs_w(wide_t v);
        return (v < 0) ? -v : v;
    endfunction

    // Quotient rounded to nearest, ties away from zero.
    function automatic wide_t div_nearest(wide_t n, wide_t d);
        wide_t an;
        wide_t ad;
        wide_t q;
        an = abs_w(n);
        ad = abs_w(d);
        if (ad == 0)
        begin
            return 0;
        end
        q = (2 * an + ad) / (2 * ad);
        return ((n < 0) != (d < 0)) ? -q : q;
    endfunction

    // Clamp to the signed coordinate range and flag overflow.
    function automatic wide_t clamp_coord(wide_t v, inout logic ovf);
        wide_t hi;
        wide_t lo;
        hi = (wide_t'(1) <<< (CW - 1)) - 1;
        lo = -(wide_t'(1) <<< (CW - 1));
        if (v > hi)
        begin
            ovf = 1'b1;
            return hi;
        end
        if (v < lo)
        begin
            ovf = 1'b1;
            return lo;
        end
        return v;
    endfunction

    function automatic wide_t dist_sq(wide_t x1, wide_t y1, wide_t x2, wide_t y2);
        return (x1 - x2) * (x1 - x2) + (y1 - y2) * (y1 - y2);
    endfunction

    // Expected result word for one request under the current tolerances.
    function automatic res_t circle_predict(req_t r);
        wide_t qx, qy, xa, ya, xb, yb, xc, yc;
        wide_t aab, abc, ct;
        wide_t xn, xd, yn, yd;
        wide_t ax, ay, ex, ey, la, lc, det;
        wide_t cx, cy, rsq, dsq;
        logic [63:0] root;
        logic [63:0] cand;
        logic ovf;
        res_t o;
        qx = r.query_x;
        qy = r.query_y;
        xa = r.vert_a_x;
        ya = r.vert_a_y;
        xb = r.vert_b_x;
        yb = r.vert_b_y;
        xc = r.vert_c_x;
        yc = r.vert_c_y;
        ct = coord_tol_m;
        aab = abs_w(ya - yb);
        abc = abs_w(yb - yc);
        o = '0;
        ovf = 1'b0;
        o.status = ST_OK;
        if (aab < ct && abc < ct)
        begin
            o.status = ST_FLAT;
            return o;
        end
        if (aab < ct)
        begin
            xn = xa + xb;
            xd = 2;
            yn = (yb + yc) * (yc - yb) - (xc - xb) * (xa - xc);
            yd = 2 * (yc - yb);
        end
        else if (abc < ct)
        begin
            xn = xb + xc;
            xd = 2;
            yn = (ya + yb) * (yb - ya) - (xb - xa) * (xc - xa);
            yd = 2 * (yb - ya);
        end
        else
        begin
            ax = xa - xb;
            ay = ya - yb;
            ex = xc - xb;
            ey = yc - yb;
            la = ax * ax + ay * ay;
            lc = ex * ex + ey * ey;
            det = ax * ey - ay * ex;
            if (det == 0)
            begin
                o.status = ST_PARALLEL;
                return o;
            end
            det = 2 * det;
            xn = xb * det + (ey * la - ay * lc);
            yn = yb * det + (ax * lc - ex * la);
            xd = det;
            yd = det;
        end
        cx = clamp_coord(div_nearest(xn, xd), ovf);
        cy = clamp_coord(div_nearest(yn, yd), ovf);
        rsq = dist_sq(xb, yb, cx, cy);
        dsq = dist_sq(qx, qy, cx, cy);
        // Bitwise integer square root, floor.
        root = '0;
        for (int b = 63; b >= 0; b--)
        begin
            cand = root | (64'd1 << b);
            if (wide_t'(cand) * wide_t'(cand) <= rsq)
            begin
                root = cand;
            end
        end
        if (root > 64'hFFFF_FFFF)
        begin
            root = 64'hFFFF_FFFF;
            ovf = 1'b1;
        end
        o.center_x = cx[CW-1:0];
        o.center_y = cy[CW-1:0];
        o.radius = root[CW-1:0];
        o.inside_res = (dsq <= rsq + wide_t'(area_tol_m));
        o.status = ovf ? ST_OVERFLOW : ST_OK;
        return o;
    endfunction

    function automatic int draw_wait();
        if (no_idle || $urandom_range(0, 3) == 0)
        begin
            return 0;
        end
        return $urandom_range(0, 16);
    endfunction

    // Request driver: a word is accepted where valid is high and stall is low.
    always @(posedge clk or negedge rst_n)
    begin
        int gap_next;
        logic valid_next;
        req_t word_next;
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req <= '0;
            send_gap <= 0;
        end
        else
        begin
            gap_next = send_gap;
            valid_next = req_valid;
            word_next = req;
            if (req_valid && !req_stall)
            begin
                circle_expected.push_back(circle_predict(req));
                words_sent++;
                valid_next = 1'b0;
                gap_next = draw_wait();
            end
            if (!(req_valid && req_stall))
            begin
                if (gap_next > 0)
                begin
                    gap_next--;
                    valid_next = 1'b0;
                end
                else if (circle_pending.size() > 0)
                begin
                    word_next = circle_pending.pop_front();
                    valid_next = 1'b1;
                end
                else
                begin
                    valid_next = 1'b0;
                end
            end
            send_gap <= gap_next;
            req_valid <= valid_next;
            req <= word_next;
        end
    end

    // Result monitor: checks each accepted word and decides the next stall.
    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        if (!rst_n)
        begin
            res_stall <= 1'b0;
            recv_gap <= 0;
            hold_left <= 0;
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                if (circle_expected.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("Unexpected result word: %p", res);
                    end
                end
                else
                begin
                    want = circle_expected.pop_front();
                    words_checked++;
                    status_seen[want.status]++;
                    if (res.center_x !== want.center_x || res.center_y !== want.center_y
                        || res.radius !== want.radius || res.inside_res !== want.inside_res
                        || res.status !== want.status)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("Mismatch on word %0d:", words_checked);
                            $display("  center_x exp %0d got %0d", want.center_x, res.center_x);
                            $display("  center_y exp %0d got %0d", want.center_y, res.center_y);
                            $display("  radius exp %0d got %0d", want.radius, res.radius);
                            $display("  inside exp %0b got %0b  status exp %s got %s",
                                     want.inside_res, res.inside_res,
                                     want.status.name(), res.status.name());
                        end
                    end
                end
            end
            if (hold_requests != hold_served)
            begin
                hold_served <= hold_requests;
                hold_left <= 300;
                res_stall <= 1'b1;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                res_stall <= 1'b1;
            end
            else if (res_valid && !res_stall)
            begin
                recv_gap <= draw_wait();
                res_stall <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap <= recv_gap - 1;
                res_stall <= 1'b1;
            end
            else
            begin
                res_stall <= 1'b0;
            end
        end
    end

    task automatic reg_write(logic reg_idx, logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (reg_idx == REG_COORD_TOL)
        begin
            coord_tol_m = value[CTOL_W-1:0];
        end
        else
        begin
            area_tol_m = value[ATOL_W-1:0];
        end
    endtask

    // Blocks until every queued word has been sent and every result checked.
    task automatic drain();
        while (circle_pending.size() > 0 || req_valid || circle_expected.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (PIPE_LATENCY + 10) @(posedge clk);
    endtask

    function automatic logic signed [CW-1:0] small_coord();
        return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
    endfunction

    function automatic logic signed [CW-1:0] near_offset();
        int span;
        span = (coord_tol_m > 0) ? coord_tol_m - 1 : 0;
        return $urandom_range(0, 1) ? $signed(32'($urandom_range(0, span)))
                                    : -$signed(32'($urandom_range(0, span)));
    endfunction

    // Random triangle: mostly well-formed, with horizontal edges, collinear
    // vertices and full-range noise mixed in.
    function automatic req_t make_triangle();
        req_t t;
        int kind;
        int k;
        kind = $urandom_range(0, 11);
        t.vert_a_x = small_coord();
        t.vert_a_y = small_coord();
        t.vert_b_x = small_coord();
        t.vert_b_y = small_coord();
        t.vert_c_x = small_coord();
        t.vert_c_y = small_coord();
        t.query_x = small_coord();
        t.query_y = small_coord();
        case (kind)
            6: t.vert_b_y = t.vert_a_y + near_offset();
            7: t.vert_c_y = t.vert_b_y + near_offset();
            8:
            begin
                t.vert_b_y = t.vert_a_y + near_offset();
                t.vert_c_y = t.vert_b_y + near_offset();
            end
            9:
            begin
                k = $urandom_range(0, 6) - 3;
                t.vert_c_x = t.vert_b_x + k * (t.vert_b_x - t.vert_a_x);
                t.vert_c_y = t.vert_b_y + k * (t.vert_b_y - t.vert_a_y);
            end
            10:
            begin
                t = {$urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom};
            end
            default:
            begin
                // Query on or near a vertex lands close to the circle.
                if ($urandom_range(0, 3) == 0)
                begin
                    t.query_x = t.vert_a_x + $signed(32'($urandom_range(0, 4))) - 2;
                    t.query_y = t.vert_a_y;
                end
            end
        endcase
        return t;
    endfunction

    function automatic req_t pts(int qx, int qy, int ax, int ay,
                                 int bx, int by, int cx, int cy);
        req_t t;
        t.query_x = qx;
        t.query_y = qy;
        t.vert_a_x = ax;
        t.vert_a_y = ay;
        t.vert_b_x = bx;
        t.vert_b_y = by;
        t.vert_c_x = cx;
        t.vert_c_y = cy;
        return t;
    endfunction

    task automatic queue_random(int count);
        repeat (count) circle_pending.push_back(make_triangle());
    endtask

    // Stimulus and configuration sequence.
    initial
    begin
        int mx;
        int mn;
        mx = 32'sh7FFF_FFFF;
        mn = 32'sh8000_0000;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        coord_tol_m = CTOL_RESET;
        area_tol_m = ATOL_RESET;
        no_idle = 1'b0;
        hold_requests = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words at the reset tolerances.
        circle_pending.push_back(pts(mn, mn, mn, mn, mn, mn, mn, mn));
        circle_pending.push_back(pts(mx, mx, mx, mx, mx, mx, mx, mx));
        circle_pending.push_back(pts(0, 0, mn, mn, mx, 0, mn, mx));
        circle_pending.push_back(pts(mx, mn, mx, mn, mn, mx, mn, mn));
        circle_pending.push_back(pts(0, 0, 0, 0, 65536, 0, 0, 65536));
        circle_pending.push_back(pts(65536, 65536, 0, 0, 65536, 0, 0, 65536));
        circle_pending.push_back(pts(65537, 65537, 0, 0, 65536, 0, 0, 65536));
        circle_pending.push_back(pts(0, 0, -3, 5, 7, 5, 1, 100));
        circle_pending.push_back(pts(0, 0, -3, 90, 7, 5, 11, 5));
        circle_pending.push_back(pts(1, 1, 0, 0, 65536, 65536, 131072, 131072));
        circle_pending.push_back(pts(0, 0, 0, 9, 100, 9, -100, 9));
        circle_pending.push_back(pts(0, 0, 0, 0, 1, 1000000, 2, 1));
        circle_pending.push_back(pts(5, 5, mn, 0, mx, 1, 0, mx));
        circle_pending.push_back(pts(-1, -1, 1, 2, 3, 5, -7, 11));
        circle_pending.push_back(pts(0, 0, 0, 0, 1, 0, 2, 3));
        queue_random(470);
        drain();

        // Zero tolerances: nothing counts as horizontal, no inside slack.
        reg_write(REG_COORD_TOL, 32'd0);
        reg_write(REG_AREA_TOL, 32'd0);
        no_idle = 1'b1;
        queue_random(120);
        repeat (40) @(posedge clk);
        hold_requests++;
        queue_random(60);
        while (circle_pending.size() > 0)
        begin
            @(posedge clk);
        end
        no_idle = 1'b0;
        queue_random(300);
        drain();

        // Largest tolerances.
        reg_write(REG_COORD_TOL, 32'hFFFF);
        reg_write(REG_AREA_TOL, 32'hFFFF_FFFF);
        queue_random(480);
        drain();

        // Random middle settings.
        reg_write(REG_COORD_TOL, $urandom_range(2, 5000));
        reg_write(REG_AREA_TOL, $urandom);
        no_idle = 1'b1;
        queue_random(150);
        while (circle_pending.size() > 0)
        begin
            @(posedge clk);
        end
        no_idle = 1'b0;
        queue_random(330);
        drain();

        $display("Checked %0d of %0d words over four tolerance settings with stalls.",
                 words_checked, words_sent);
        $display("Status mix: ok %0d, flat %0d, parallel %0d, overflow %0d.",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
        if (mismatches == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Watchdog.
    initial
    begin
        #(2 * HALF_PERIOD * 2000000);
        $display("Timeout with %0d results outstanding.", circle_expected.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/cic_pkg.sv
rtl/cic_div_cell.sv
rtl/cic_sqrt_cell.sv
rtl/circumcircle_incircle_test.sv
verif/testbench.sv
